// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/rwlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rwlt_pkg;

  localparam int NUM_FILES   = 8;
  localparam int NUM_PROCS   = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int CMD_W  = 2;
  localparam int FILE_W = 3;
  localparam int PROC_W = 4;
  localparam int KIND_W = 3;
  localparam int MODE_W = 2;

  localparam int FIDX_W     = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int QIDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int HOLD_W     = NUM_PROCS;
  localparam int WAIT_DEPTH = NUM_FILES * QUEUE_DEPTH;
  localparam int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

  localparam logic [CMD_W-1:0] CMD_OPEN_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE      = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WOKEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILE,
    ST_HEAD,
    ST_NEXT,
    ST_FINAL
  } state_t;

  // One row of the per-file lock table.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOLD_W-1:0] holders;
    logic [QIDX_W-1:0] head;
    logic [QCNT_W-1:0] count;
  } file_ent_t;

  // One waiting open request.
  typedef struct packed {
    logic              is_write;
    logic [PROC_W-1:0] proc;
  } wait_ent_t;

  localparam int FILE_ENT_W = $bits(file_ent_t);
  localparam int WAIT_ENT_W = $bits(wait_ent_t);

  typedef struct packed {
    logic              re;
    logic [FIDX_W-1:0] raddr;
    logic              we;
    logic [FIDX_W-1:0] waddr;
    file_ent_t         wdata;
  } file_port_t;

  typedef struct packed {
    logic               re;
    logic [WAIT_AW-1:0] raddr;
    logic               we;
    logic [WAIT_AW-1:0] waddr;
    wait_ent_t          wdata;
  } wait_port_t;

  function automatic logic [WAIT_AW-1:0] wait_addr(input logic [FIDX_W-1:0] f,
                                                   input logic [QIDX_W-1:0] s);
    return WAIT_AW'(int'(f) * QUEUE_DEPTH + int'(s));
  endfunction

  function automatic logic [QIDX_W-1:0] qidx_inc(input logic [QIDX_W-1:0] s);
    return (s == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + QIDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rwlt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rwlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rwlt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rwlt_engine
  import rwlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [FILE_W-1:0]     file_id,
  input  logic [PROC_W-1:0]     process_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     kind,
  output logic [PROC_W-1:0]     who,
  output logic [MODE_W-1:0]     lock_mode,
  output logic                  last,
  output file_port_t            file_port,
  input  logic [FILE_ENT_W-1:0] file_rdata,
  output wait_port_t            wait_port,
  input  logic [WAIT_ENT_W-1:0] wait_rdata
);

  state_t            state, state_next;
  logic [CMD_W-1:0]  req_cmd;
  logic [FIDX_W-1:0] req_file;
  logic [PROC_W-1:0] req_proc;
  logic [NUM_FILES-1:0] file_valid;
  logic              rd_valid;
  file_ent_t         cur, cur_next;
  logic [PROC_W-1:0] pend_proc, pend_proc_next;

  logic              in_acc, req_ok, slot_free;
  file_ent_t         f_ent;
  wait_ent_t         head_ent;
  logic [HOLD_W-1:0] proc_bit, hold_after, head_bit;
  logic              want_write, grant, close_wake;

  logic              emit, e_last;
  logic [KIND_W-1:0] e_kind;
  logic [PROC_W-1:0] e_who;
  logic [MODE_W-1:0] e_mode;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign req_ok    = (command == CMD_OPEN_READ || command == CMD_OPEN_WRITE ||
                      command == CMD_CLOSE) &&
                     (int'(file_id) < NUM_FILES) && (int'(process_id) < NUM_PROCS);

  // a row never written reads as a free lock
  assign f_ent      = rd_valid ? file_ent_t'(file_rdata) : '0;
  assign head_ent   = wait_ent_t'(wait_rdata);
  assign proc_bit   = HOLD_W'(1) << req_proc;
  assign head_bit   = HOLD_W'(1) << head_ent.proc;
  assign hold_after = f_ent.holders & ~proc_bit;
  assign want_write = (req_cmd == CMD_OPEN_WRITE);
  assign grant      = want_write ? (f_ent.mode == MODE_NONE) : (f_ent.mode != MODE_WRITE);
  assign close_wake = (req_cmd == CMD_CLOSE) && (hold_after == '0) && (f_ent.count != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && req_ok) state_next = ST_FILE;
      ST_FILE:  if (slot_free) state_next = close_wake ? ST_HEAD : ST_IDLE;
      ST_HEAD: begin
        if (slot_free) begin
          state_next = (head_ent.is_write || cur.count == QCNT_W'(1)) ? ST_FINAL : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (slot_free) begin
          if (head_ent.is_write) begin
            state_next = ST_IDLE;
          end else if (cur.count == QCNT_W'(1)) begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FINAL: if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [QCNT_W:0] slot_sum;
    cur_next       = cur;
    pend_proc_next = pend_proc;
    file_port      = '0;
    wait_port      = '0;
    emit           = 1'b0;
    e_kind         = KIND_GRANTED;
    e_who          = req_proc;
    e_mode         = MODE_NONE;
    e_last         = 1'b0;
    slot_sum = (QCNT_W+1)'(f_ent.head) + (QCNT_W+1)'(f_ent.count);
    if (slot_sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (QCNT_W+1)'(QUEUE_DEPTH);
    end
    unique case (state)
      ST_IDLE: begin
        file_port.re    = in_acc && req_ok;
        file_port.raddr = FIDX_W'(file_id);
      end
      ST_FILE: begin
        if (slot_free) begin
          file_port.waddr = req_file;
          if (req_cmd == CMD_CLOSE) begin
            if (close_wake) begin
              // holders gone and someone waits: fetch the queue head
              cur_next         = f_ent;
              cur_next.holders = hold_after;
              wait_port.re     = 1'b1;
              wait_port.raddr  = wait_addr(req_file, f_ent.head);
            end else begin
              file_port.we            = 1'b1;
              file_port.wdata         = f_ent;
              file_port.wdata.holders = hold_after;
              if (hold_after == '0) begin
                file_port.wdata.mode = MODE_NONE;
              end
              emit   = 1'b1;
              e_kind = KIND_CLOSED;
              e_mode = file_port.wdata.mode;
              e_last = 1'b1;
            end
          end else begin
            file_port.we    = 1'b1;
            file_port.wdata = f_ent;
            emit            = 1'b1;
            e_last          = 1'b1;
            if (grant) begin
              if (f_ent.mode == MODE_NONE) begin
                file_port.wdata.mode    = want_write ? MODE_WRITE : MODE_READ;
                file_port.wdata.holders = proc_bit;
              end else begin
                file_port.wdata.holders = f_ent.holders | proc_bit;
              end
              e_kind = KIND_GRANTED;
            end else if (f_ent.count < QCNT_W'(QUEUE_DEPTH)) begin
              file_port.wdata.count = f_ent.count + QCNT_W'(1);
              wait_port.we          = 1'b1;
              wait_port.waddr       = wait_addr(req_file, QIDX_W'(slot_sum));
              wait_port.wdata       = '{is_write: want_write, proc: req_proc};
              e_kind                = KIND_QUEUED;
            end else begin
              e_kind = KIND_FULL;
            end
            e_mode = file_port.wdata.mode;
          end
        end
      end
      ST_HEAD: begin
        if (slot_free) begin
          // the head decides the final mode, so the closed item goes out now
          emit             = 1'b1;
          e_kind           = KIND_CLOSED;
          e_mode           = head_ent.is_write ? MODE_WRITE : MODE_READ;
          cur_next.mode    = e_mode;
          cur_next.holders = head_bit;
          cur_next.head    = qidx_inc(cur.head);
          cur_next.count   = cur.count - QCNT_W'(1);
          pend_proc_next   = head_ent.proc;
          if (!head_ent.is_write && cur.count != QCNT_W'(1)) begin
            wait_port.re    = 1'b1;
            wait_port.raddr = wait_addr(req_file, qidx_inc(cur.head));
          end
        end
      end
      ST_NEXT: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = KIND_WOKEN;
          e_who  = pend_proc;
          e_mode = cur.mode;
          if (head_ent.is_write) begin
            // a writer ends the run of readers
            e_last          = 1'b1;
            file_port.we    = 1'b1;
            file_port.waddr = req_file;
            file_port.wdata = cur;
          end else begin
            pend_proc_next   = head_ent.proc;
            cur_next.holders = cur.holders | head_bit;
            cur_next.head    = qidx_inc(cur.head);
            cur_next.count   = cur.count - QCNT_W'(1);
            if (cur.count != QCNT_W'(1)) begin
              wait_port.re    = 1'b1;
              wait_port.raddr = wait_addr(req_file, qidx_inc(cur.head));
            end
          end
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          emit            = 1'b1;
          e_kind          = KIND_WOKEN;
          e_who           = pend_proc;
          e_mode          = cur.mode;
          e_last          = 1'b1;
          file_port.we    = 1'b1;
          file_port.waddr = req_file;
          file_port.wdata = cur;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      file_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (file_port.we) begin
        file_valid[file_port.waddr] <= 1'b1;
      end
      if (file_port.re) begin
        rd_valid <= file_valid[file_port.raddr];
      end
    end
    if (in_acc) begin
      req_cmd  <= command;
      req_file <= FIDX_W'(file_id);
      req_proc <= process_id;
    end
    cur       <= cur_next;
    pend_proc <= pend_proc_next;
    if (emit) begin
      kind      <= e_kind;
      who       <= e_who;
      lock_mode <= e_mode;
      last      <= e_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/reader_writer_lock_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reader/writer lock table: one lock and one FIFO wait queue per file.
// Input channel (in_valid/in_stall): command, file_id, process_id. An open
// gives one item (granted, queued or queue full); a close gives a closed item
// and then one woken item per process let in from the queue, in queue order.
// Every item carries the file's lock mode after the whole request; the final
// item of a request has last set. Requests with an unused command or an
// out-of-range file or process are taken and give no item.
// Sequence: an open or a close that wakes nobody is accepted, then the lock
// row is read and written back. A close that wakes processes also reads the
// wait queue once per woken process, and once more for a writer that ends a
// run of readers; each read lands in the wait RAM's output register. One
// request is in work at a time; in_stall is high while it is.
// Output channel (out_valid/out_stall): a registered output stage. A stall
// holds the item and freezes the sequencer until the stage frees up.
// Reset clears the state machine, the output stage and the valid bit of each
// lock-table row, so every file reads as free with an empty queue. Wait-queue
// RAM is not cleared: only entries that were written are ever read.
`include "assert_macros.svh"

module reader_writer_lock_table
  import rwlt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [FILE_W-1:0] file_id,
  input  logic [PROC_W-1:0] process_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] kind,
  output logic [PROC_W-1:0] who,
  output logic [MODE_W-1:0] lock_mode,
  output logic              last
);

  file_port_t            file_port;
  wait_port_t            wait_port;
  logic [FILE_ENT_W-1:0] file_rdata;
  logic [WAIT_ENT_W-1:0] wait_rdata;

  // sequencer: decode, read-modify-write of the lock row, queue walk
  rwlt_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .file_id    (file_id),
    .process_id (process_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .who        (who),
    .lock_mode  (lock_mode),
    .last       (last),
    .file_port  (file_port),
    .file_rdata (file_rdata),
    .wait_port  (wait_port),
    .wait_rdata (wait_rdata)
  );

  // lock table: mode, holder set, queue head and count per file
  rwlt_ram #(
    .WIDTH (FILE_ENT_W),
    .DEPTH (NUM_FILES)
  ) u_file_ram (
    .clk   (clk),
    .we    (file_port.we),
    .waddr (file_port.waddr),
    .wdata (file_port.wdata),
    .re    (file_port.re),
    .raddr (file_port.raddr),
    .rdata (file_rdata)
  );

  // wait queues: QUEUE_DEPTH slots per file, process plus write flag
  rwlt_ram #(
    .WIDTH (WAIT_ENT_W),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (wait_port.we),
    .waddr (wait_port.waddr),
    .wdata (wait_port.wdata),
    .re    (wait_port.re),
    .raddr (wait_port.raddr),
    .rdata (wait_rdata)
  );

  // the sequencer never reads and writes back a lock row in the same cycle
  `ASSERT_IMPLIES(a_file_rw_excl, clk, rst, file_port.we, !file_port.re, "lock row read and write overlap")
  // writes to the lock table happen only while a request is in work
  `ASSERT_IMPLIES(a_write_busy, clk, rst, file_port.we, in_stall, "lock table written while idle")
  // an open gives exactly one item
  `ASSERT_IMPLIES(a_open_last, clk, rst, out_valid && kind != KIND_CLOSED && kind != KIND_WOKEN, last, "open item without last")
  // a woken process always leaves the lock held
  `ASSERT_IMPLIES(a_woken_mode, clk, rst, out_valid && kind == KIND_WOKEN, lock_mode != MODE_NONE, "woken item with free lock")

endmodule

`default_nettype wire

// ===== tb/reader_writer_lock_table_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the reader/writer lock table.
// A directed pass walks the lock rules on a few files. A second pass fills one
// wait queue to the brim behind a writer while the result side is held off,
// then wakes all sixteen readers at once. A long random pass follows. A
// behavioral model of the lock table, kept in this file, predicts every
// result item. The checker compares each accepted result with the oldest
// prediction.
module reader_writer_lock_table_tb;
  import rwlt_pkg::*;

  localparam int                 CLK_HALF    = 6;
  localparam int                 CYCLE_LIMIT = 400000;
  localparam int                 DRAIN_CYCLES = 24;   // longest close: a closed item plus 16 wakes
  localparam int                 RANDOM_ITEMS = 350;
  localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;

  // One result item as the block should deliver it.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PROC_W-1:0] who;
    logic [MODE_W-1:0] mode;
    logic              last;
  } lock_result_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command    = CMD_OPEN_READ;
  logic [FILE_W-1:0] file_id    = '0;
  logic [PROC_W-1:0] process_id = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [PROC_W-1:0] who;
  logic [MODE_W-1:0] lock_mode;
  logic              last;

  // Lock table as the testbench sees it.
  logic [MODE_W-1:0]    lk_mode    [NUM_FILES];
  logic [NUM_PROCS-1:0] lk_holders [NUM_FILES];
  wait_ent_t            lk_wait    [NUM_FILES][QUEUE_DEPTH];
  int                   lk_head    [NUM_FILES];
  int                   lk_count   [NUM_FILES];

  lock_result_t pending_results[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  bit           no_idle     = 1'b0;  // both sides run without gaps while set
  int           hold_off    = 0;     // cycles the result side must stay stalled

  reader_writer_lock_table i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .file_id    (file_id),
    .process_id (process_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .who        (who),
    .lock_mode  (lock_mode),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Apply one accepted request to the lock table and queue the results it
  // causes. Every result carries the mode left after the whole request.
  function automatic void apply_request(input logic [CMD_W-1:0]  cmd,
                                        input logic [FILE_W-1:0] f,
                                        input logic [PROC_W-1:0] p);
    lock_result_t res[$];
    wait_ent_t    slot;
    bit           want_write;
    bit           grant;
    if (cmd != CMD_OPEN_READ && cmd != CMD_OPEN_WRITE && cmd != CMD_CLOSE) return;
    if (int'(f) >= NUM_FILES || int'(p) >= NUM_PROCS) return;
    if (cmd == CMD_CLOSE) begin
      lk_holders[f][p] = 1'b0;
      res.push_back(lock_result_t'{KIND_CLOSED, p, MODE_NONE, 1'b0});
      if (lk_holders[f] == '0) begin
        if (lk_count[f] > 0) begin
          // Pop the head into the lock; a reader head keeps pulling readers.
          slot = lk_wait[f][lk_head[f]];
          lk_mode[f] = slot.is_write ? MODE_WRITE : MODE_READ;
          do begin
            lk_holders[f][slot.proc] = 1'b1;
            res.push_back(lock_result_t'{KIND_WOKEN, slot.proc, MODE_NONE, 1'b0});
            lk_head[f] = (lk_head[f] + 1) % QUEUE_DEPTH;
            lk_count[f]--;
            slot = lk_wait[f][lk_head[f]];
          end while (lk_mode[f] == MODE_READ && lk_count[f] > 0 && !slot.is_write);
        end else begin
          lk_mode[f] = MODE_NONE;
        end
      end
    end else begin
      want_write = (cmd == CMD_OPEN_WRITE);
      grant = want_write ? (lk_mode[f] == MODE_NONE) : (lk_mode[f] != MODE_WRITE);
      if (grant) begin
        if (lk_mode[f] == MODE_NONE) begin
          lk_mode[f]    = want_write ? MODE_WRITE : MODE_READ;
          lk_holders[f] = '0;
        end
        lk_holders[f][p] = 1'b1;
        res.push_back(lock_result_t'{KIND_GRANTED, p, MODE_NONE, 1'b0});
      end else if (lk_count[f] < QUEUE_DEPTH) begin
        slot.is_write = want_write;
        slot.proc     = p;
        lk_wait[f][(lk_head[f] + lk_count[f]) % QUEUE_DEPTH] = slot;
        lk_count[f]++;
        res.push_back(lock_result_t'{KIND_QUEUED, p, MODE_NONE, 1'b0});
      end else begin
        res.push_back(lock_result_t'{KIND_FULL, p, MODE_NONE, 1'b0});
      end
    end
    foreach (res[i]) res[i].mode = lk_mode[f];
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  // Offer one request, hold it until taken, then predict its results.
  // With a zero gap valid stays high and only the payload advances.
  task automatic send_request(input logic [CMD_W-1:0]  cmd,
                              input logic [FILE_W-1:0] f,
                              input logic [PROC_W-1:0] p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    file_id    <= f;
    process_id <= p;
    do @(posedge clk); while (in_stall);
    apply_request(cmd, f, p);
  endtask

  // Drop valid and let every predicted result come out, plus some slack.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: draw a stall length for every item; a requested hold-off
  // takes priority and is counted down here, one cycle per edge.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    lock_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d who %0d lock_mode %0d last %0d",
               kind, who, lock_mode, last);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (kind !== exp_res.kind) begin
          $error("kind: expected %0d, actual %0d", exp_res.kind, kind);
          mismatches++;
        end
        if (who !== exp_res.who) begin
          $error("who: expected %0d, actual %0d", exp_res.who, who);
          mismatches++;
        end
        if (lock_mode !== exp_res.mode) begin
          $error("lock_mode: expected %0d, actual %0d", exp_res.mode, lock_mode);
          mismatches++;
        end
        if (last !== exp_res.last) begin
          $error("last: expected %0d, actual %0d", exp_res.last, last);
          mismatches++;
        end
      end
    end
  end

  // Walk the lock rules: sharing, reader preference, non-holder and queued
  // closes, a close of a free lock, wake chains that stop at a writer, a
  // repeat write open by its own holder, and the unused command.
  task automatic test_lock_rules();
    send_request(CMD_CLOSE,      3'd0, 4'd0);   // free lock, mode stays none
    send_request(CMD_OPEN_READ,  3'd0, 4'd15);
    send_request(CMD_OPEN_READ,  3'd0, 4'd3);   // readers share
    send_request(CMD_OPEN_READ,  3'd0, 4'd15);  // reader opens again
    send_request(CMD_OPEN_WRITE, 3'd0, 4'd0);   // queued behind readers
    send_request(CMD_OPEN_READ,  3'd0, 4'd5);   // readers still let in
    send_request(CMD_CLOSE,      3'd0, 4'd9);   // not a holder
    send_request(CMD_CLOSE,      3'd0, 4'd0);   // waiting, not holding
    send_request(CMD_CLOSE,      3'd0, 4'd15);
    send_request(CMD_CLOSE,      3'd0, 4'd3);
    send_request(CMD_CLOSE,      3'd0, 4'd5);   // wakes the writer
    send_request(CMD_OPEN_READ,  3'd0, 4'd1);
    send_request(CMD_OPEN_READ,  3'd0, 4'd2);
    send_request(CMD_OPEN_WRITE, 3'd0, 4'd4);
    send_request(CMD_OPEN_READ,  3'd0, 4'd6);
    send_request(CMD_CLOSE,      3'd0, 4'd0);   // wakes two readers, stops at writer
    send_request(CMD_UNUSED,     3'd7, 4'd15);  // ignored
    send_request(CMD_OPEN_WRITE, 3'd7, 4'd15);
    send_request(CMD_OPEN_WRITE, 3'd7, 4'd15);  // holder asks again: queued
    send_request(CMD_CLOSE,      3'd7, 4'd15);  // wakes itself
    send_request(CMD_CLOSE,      3'd7, 4'd15);
    send_request(CMD_CLOSE,      3'd0, 4'd1);
    send_request(CMD_CLOSE,      3'd0, 4'd2);   // wakes writer
    send_request(CMD_CLOSE,      3'd0, 4'd4);   // wakes last reader
    send_request(CMD_CLOSE,      3'd0, 4'd6);
    wait_for_results();
  endtask

  // Fill one queue with sixteen readers behind a writer while the result
  // side holds off, overflow it once, then release them all with one close.
  task automatic test_full_queue_wake();
    int i;
    send_request(CMD_OPEN_WRITE, 3'd3, 4'd0);
    wait_for_results();
    no_idle  = 1'b1;
    hold_off = 400;
    for (i = 0; i < NUM_PROCS; i++) send_request(CMD_OPEN_READ, 3'd3, PROC_W'(i));
    send_request(CMD_OPEN_WRITE, 3'd3, 4'd7);   // queue full, dropped
    send_request(CMD_CLOSE,      3'd3, 4'd0);   // closed plus sixteen wakes
    for (i = NUM_PROCS - 1; i >= 0; i--) send_request(CMD_CLOSE, 3'd3, PROC_W'(i));
    no_idle = 1'b0;
    wait_for_results();
  endtask

  // Random opens and closes, most on a few busy files; most closes come
  // from a real holder so that queues drain and wake chains form.
  task automatic test_random_traffic(input int num_items);
    int                sent;
    int                r;
    logic [CMD_W-1:0]  cmd;
    logic [FILE_W-1:0] f;
    logic [PROC_W-1:0] p;
    sent = 0;
    while (sent < num_items) begin
      if (sent % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      f = ($urandom_range(0, 99) < 70) ? FILE_W'($urandom_range(0, 2))
                                       : FILE_W'($urandom_range(0, NUM_FILES - 1));
      p = PROC_W'($urandom_range(0, NUM_PROCS - 1));
      if (r < 40) begin
        cmd = CMD_OPEN_READ;
      end else if (r < 60) begin
        cmd = CMD_OPEN_WRITE;
      end else if (r < 96) begin
        cmd = CMD_CLOSE;
        if (r < 90 && lk_holders[f] != '0) begin
          while (!lk_holders[f][p]) p = PROC_W'($urandom_range(0, NUM_PROCS - 1));
        end
      end else begin
        cmd = CMD_UNUSED;
      end
      send_request(cmd, f, p);
      if (cmd != CMD_UNUSED) sent++;
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  initial begin
    for (int f = 0; f < NUM_FILES; f++) begin
      lk_mode[f]    = MODE_NONE;
      lk_holders[f] = '0;
      lk_head[f]    = 0;
      lk_count[f]   = 0;
      for (int s = 0; s < QUEUE_DEPTH; s++) lk_wait[f][s] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lock_rules();
    test_full_queue_wake();
    test_random_traffic(RANDOM_ITEMS);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
